>>> rtl/fpr_pkg.sv
// Shared constants and types for the framed packet receiver.
package fpr_pkg;

    // One past the largest accepted payload length; a length byte at or above it means empty.
    localparam int unsigned MAX_PAYLOAD = 60;

    // Payload counters never exceed MAX_PAYLOAD-1.
    localparam int unsigned SEEN_W = $clog2(MAX_PAYLOAD);
    // Frame index reaches at most 4 + (MAX_PAYLOAD-1).
    localparam int unsigned IDX_W  = $clog2(MAX_PAYLOAD + 4);

    localparam logic [7:0]  START_BYTE = 8'h2A;  // '*'
    localparam logic [7:0]  END_BYTE   = 8'h23;  // '#'
    localparam logic [15:0] SUM_WEIGHT = 16'd87;

    // Frame indices whose bytes hold the program header fields.
    localparam logic [IDX_W-1:0] FIELD_FIRST = IDX_W'(3);
    localparam logic [IDX_W-1:0] FIELD_LAST  = IDX_W'(6);

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_WAIT   = 5'b00001,
        PH_LEN    = 5'b00010,
        PH_PAY    = 5'b00100,
        PH_CHK_HI = 5'b01000,
        PH_END    = 5'b10000
    } phase_t;

    // What the parser hands to the result register for one byte.
    typedef struct packed {
        logic        hit;
        logic [15:0] block_number;
        logic [15:0] block_count;
    } result_t;

endpackage

>>> rtl/fpr_input_reg.sv
// Input register: holds one received byte until the parser takes it.
module fpr_input_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    // Stall only while a byte is held and the parser cannot move.
    assign rx_stall = valid_reg && !advance;
    assign accept   = rx_valid && !rx_stall;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= rx_byte;
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

>>> rtl/fpr_parser.sv
// Frame parser: phase, payload counters, running checksum and header bytes.
module fpr_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           rx_data,
    output fpr_pkg::result_t     result
);

    fpr_pkg::phase_t                 phase_reg, phase_next;
    logic [fpr_pkg::SEEN_W-1:0]      len_reg, len_next;
    logic [fpr_pkg::SEEN_W-1:0]      seen_reg, seen_next;
    logic [15:0]                     sum_reg, sum_next;
    logic [7:0]                      chk_low_reg, chk_low_next;
    logic [7:0]                      field_reg [4];
    logic [7:0]                      field_next [4];

    logic [2:0]                      phase_num;
    logic [fpr_pkg::IDX_W-1:0]       frame_idx;
    logic [fpr_pkg::IDX_W-1:0]       field_off;
    logic [15:0]                     weighted;
    logic                            hit;

    // Numeric phase for the frame index.
    always_comb
    begin
        unique case (phase_reg)
            fpr_pkg::PH_WAIT:   phase_num = 3'd0;
            fpr_pkg::PH_LEN:    phase_num = 3'd1;
            fpr_pkg::PH_PAY:    phase_num = 3'd2;
            fpr_pkg::PH_CHK_HI: phase_num = 3'd3;
            fpr_pkg::PH_END:    phase_num = 3'd4;
            default:            phase_num = 3'd0;
        endcase
    end

    assign frame_idx = fpr_pkg::IDX_W'(phase_num) + fpr_pkg::IDX_W'(seen_reg);
    assign field_off = frame_idx - fpr_pkg::FIELD_FIRST;
    assign weighted  = 16'({8'h00, rx_data} * fpr_pkg::SUM_WEIGHT);

    // Record the byte when it sits at a header position.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            field_next[i] = field_reg[i];
        if (frame_idx >= fpr_pkg::FIELD_FIRST && frame_idx <= fpr_pkg::FIELD_LAST)
            field_next[field_off[1:0]] = rx_data;
    end

    // Phase sequencing and checksum.
    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        seen_next    = seen_reg;
        sum_next     = sum_reg;
        chk_low_next = chk_low_reg;
        hit          = 1'b0;
        unique case (phase_reg)
            fpr_pkg::PH_WAIT:
            begin
                if (rx_data == fpr_pkg::START_BYTE)
                begin
                    sum_next   = weighted;
                    phase_next = fpr_pkg::PH_LEN;
                end
            end
            fpr_pkg::PH_LEN:
            begin
                // Oversized length still enters the checksum, payload is empty
                if ({1'b0, rx_data} >= 9'(fpr_pkg::MAX_PAYLOAD))
                    len_next = '0;
                else
                    len_next = rx_data[fpr_pkg::SEEN_W-1:0];
                seen_next  = '0;
                sum_next   = sum_reg + weighted;
                phase_next = fpr_pkg::PH_PAY;
            end
            fpr_pkg::PH_PAY:
            begin
                if (len_reg > seen_reg)
                begin
                    seen_next = seen_reg + fpr_pkg::SEEN_W'(1);
                    sum_next  = sum_reg + weighted;
                end
                else
                begin
                    chk_low_next = rx_data;
                    phase_next   = fpr_pkg::PH_CHK_HI;
                end
            end
            fpr_pkg::PH_CHK_HI:
            begin
                // A matching checksum leaves zero
                sum_next   = sum_reg ^ {rx_data, chk_low_reg};
                phase_next = fpr_pkg::PH_END;
            end
            fpr_pkg::PH_END:
            begin
                hit        = (rx_data == fpr_pkg::END_BYTE) && (sum_reg == 16'h0000);
                seen_next  = '0;
                phase_next = fpr_pkg::PH_WAIT;
            end
            default:
            begin
                seen_next  = '0;
                phase_next = fpr_pkg::PH_WAIT;
            end
        endcase
    end

    assign result.hit          = hit;
    assign result.block_number = {field_next[1], field_next[0]};
    assign result.block_count  = {field_next[3], field_next[2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= fpr_pkg::PH_WAIT;
            len_reg     <= '0;
            seen_reg    <= '0;
            sum_reg     <= '0;
            chk_low_reg <= '0;
            for (int i = 0; i < 4; i++)
                field_reg[i] <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            seen_reg    <= seen_next;
            sum_reg     <= sum_next;
            chk_low_reg <= chk_low_next;
            for (int i = 0; i < 4; i++)
                field_reg[i] <= field_next[i];
        end
    end

endmodule

>>> rtl/fpr_result_reg.sv
// Result register: holds one decoded header until the receiver takes it.
module fpr_result_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    input  fpr_pkg::result_t result,
    output logic             advance,
    output logic             res_valid,
    input  logic             res_stall,
    output logic [15:0]      block_number,
    output logic [15:0]      block_count
);

    logic        valid_reg;
    logic        valid_next;
    logic [15:0] number_reg;
    logic [15:0] count_reg;
    logic        load;

    // Parser moves whenever the result slot is empty or being drained.
    assign advance = !valid_reg || !res_stall;
    assign load    = advance && byte_valid;

    always_comb
    begin
        if (load)
            valid_next = result.hit;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && result.hit)
        begin
            number_reg <= result.block_number;
            count_reg  <= result.block_count;
        end
    end

    assign res_valid    = valid_reg;
    assign block_number = number_reg;
    assign block_count  = count_reg;

endmodule

>>> rtl/framed_packet_receiver.sv
// Top level of the framed packet receiver.
//
// Input channel rx_valid/rx_stall/rx_byte carries one received byte per
// transfer. Frames are '*', a length byte, the payload, a checksum (low byte
// first) and '#'. The result channel res_valid/res_stall carries one transfer
// per good frame: block_number and block_count from the program header.
// A byte held in the input register is parsed as the result register loads,
// so a result shows on res_valid once the closing '#' has been parsed.
// Throughput: one byte per cycle; the parser state update is a weighted add
// and compare per byte between the input register and the result register.
// When res_stall holds a pending result, parsing pauses; one more byte is
// held in the input register and rx_stall rises after that.
// Reset (rst_n low, asynchronous) returns the parser to waiting for a start
// byte, clears the checksum, counters and header bytes, and empties both
// registers.
module framed_packet_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [15:0] block_number,
    output logic [15:0] block_count
);

    logic             advance;
    logic             byte_valid;
    logic [7:0]       byte_data;
    fpr_pkg::result_t result;

    fpr_input_reg u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    fpr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (byte_valid && advance),
        .rx_data (byte_data),
        .result  (result)
    );

    fpr_result_reg u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .result       (result),
        .advance      (advance),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .block_number (block_number),
        .block_count  (block_count)
    );

endmodule

>>> rtl/fpr_checker.sv
// Port-level checker for the framed packet receiver, with its bind.
module fpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_valid,
    input logic        rx_stall,
    input logic [7:0]  rx_byte,
    input logic        res_valid,
    input logic        res_stall,
    input logic [15:0] block_number,
    input logic [15:0] block_count
);

    // A stalled result holds its value.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(block_number)
            && $stable(block_count))
        else $error("stalled result changed or dropped");

    // A stalled input byte stays offered and unchanged.
    a_rx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_stall |=> rx_valid && $stable(rx_byte))
        else $error("stalled input byte changed or dropped");

    // Input backpressure only comes from a pending, stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> res_valid && res_stall)
        else $error("input stalled without a stalled result");

    // Frames are at least five bytes, so results never come back to back.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall |=> !res_valid)
        else $error("result followed a result transfer immediately");

    // The receiver never stalls input while the result slot is empty.
    a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !rx_stall)
        else $error("input stalled with the result slot empty");

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .block_number (block_number),
    .block_count  (block_count)
);
